// File: hdl/lrl_pkg.sv
// Shared constants and codes for the LRU recency list.
// Used by the channel interfaces and by the top-level module of the block.
package lrl_pkg;

  localparam int unsigned SLOTS_DEF      = 64;
  localparam int unsigned VALUE_BITS_DEF = 32;
  localparam int unsigned CAP_W          = 7;
  localparam int unsigned CAP_RESET      = 64;
  localparam int unsigned HASH_W         = 64;
  localparam int unsigned HANDLE_W       = 32;

  typedef enum logic {
    OP_PROMOTE = 1'b0,
    OP_INSERT  = 1'b1
  } op_e;

  typedef enum logic {
    STATUS_OK          = 1'b0,
    STATUS_UNALLOCATED = 1'b1
  } status_e;

endpackage

// File: hdl/lrl_if.sv
// Valid/ready channel interfaces of the LRU recency list: request, response, config.
// Depends on lrl_pkg for field widths and codes.
interface lrl_req_if #(
  parameter int unsigned SLOTS = lrl_pkg::SLOTS_DEF
);
  import lrl_pkg::*;
  localparam int unsigned SlotW = $clog2(SLOTS);

  logic                valid;
  logic                ready;
  op_e                 op;
  logic [SlotW-1:0]    slot;
  logic [HASH_W-1:0]   key_hash;
  logic [HANDLE_W-1:0] value_handle;

  modport source (output valid, op, slot, key_hash, value_handle, input ready);
  modport sink   (input valid, op, slot, key_hash, value_handle, output ready);
endinterface

interface lrl_rsp_if #(
  parameter int unsigned SLOTS = lrl_pkg::SLOTS_DEF
);
  import lrl_pkg::*;
  localparam int unsigned SlotW = $clog2(SLOTS);

  logic                valid;
  logic                ready;
  status_e             status;
  logic [SlotW-1:0]    used_slot;
  logic                evicted;
  logic [HASH_W-1:0]   evicted_hash;
  logic [HANDLE_W-1:0] evicted_value;

  modport source (output valid, status, used_slot, evicted, evicted_hash, evicted_value,
                  input ready);
  modport sink   (input valid, status, used_slot, evicted, evicted_hash, evicted_value,
                  output ready);
endinterface

interface lrl_cfg_if;
  import lrl_pkg::*;

  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// File: hdl/lrl_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; used for the per-slot hash and value store.
module lrl_ram #(
  parameter  int unsigned WIDTH = 8,
  parameter  int unsigned DEPTH = 16,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/lru_recency_list.sv
// LRU recency list top level: one request per cycle while the response side is ready, one
// response per request. A request is taken into an input register and, once the response
// register is free or being read, resolved from there into the response register, and with
// a ready response side a new request is accepted in every cycle. The ordering is held as one
// rank per slot (0 for the most recently used) in a row of per-slot cells that all update
// together when a request is resolved; the key hash and value handle of each slot live in a
// RAM whose registered read port always tracks the current tail, so the evicted data is at
// hand when an eviction is resolved. No clearing pass runs after reset. The capacity register
// may be written while the block is idle; 0 acts as 1 and values above SLOTS act as SLOTS.
module lru_recency_list #(
  parameter int unsigned SLOTS      = lrl_pkg::SLOTS_DEF,
  parameter int unsigned VALUE_BITS = lrl_pkg::VALUE_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lrl_cfg_if.sink   cfg_i,
  lrl_req_if.sink   req_i,
  lrl_rsp_if.source rsp_o
);
  import lrl_pkg::*;

  localparam int unsigned SlotW       = $clog2(SLOTS);
  localparam int unsigned CntW        = $clog2(SLOTS + 1);
  localparam int unsigned CmpW        = (CntW > CAP_W) ? CntW : CAP_W;
  localparam int unsigned StoreW      = (VALUE_BITS < HANDLE_W) ? VALUE_BITS : HANDLE_W;
  localparam int unsigned MemW        = HASH_W + StoreW;
  localparam int unsigned CapResetEff = (CAP_RESET > SLOTS) ? SLOTS : CAP_RESET;

  logic [CmpW-1:0]   eff_cap_q, eff_cap_d, cap_ext;
  logic              req_valid_q, req_valid_d;
  op_e               req_op_q;
  logic [SlotW-1:0]  req_slot_q;
  logic [HASH_W-1:0] req_hash_q;
  logic [StoreW-1:0] req_value_q;
  logic              rsp_valid_q, rsp_valid_d;
  status_e           rsp_status_q;
  logic [SlotW-1:0]  rsp_slot_q;
  logic              rsp_evicted_q;
  logic [HASH_W-1:0] rsp_hash_q;
  logic [StoreW-1:0] rsp_value_q;
  logic [SlotW-1:0]  head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]   count_q, count_d, count_m2;
  logic              byp_hit_q, byp_hit_d;
  logic [MemW-1:0]   byp_data_q, ram_wdata, ram_rdata, ev_data;

  logic              req_take, advance, is_ins, alloc_slot, full, do_op, evicting;
  logic [SlotW-1:0]  ins_slot, tgt, slot_rank, prev_tail;
  logic [SLOTS-1:0]  alloc;
  logic [SlotW-1:0]  rank_q [SLOTS];

  // Configuration: the clamped capacity is kept so the full check is a single compare.
  assign cfg_i.ready = 1'b1;

  always_comb begin
    cap_ext   = CmpW'(cfg_i.data);
    eff_cap_d = eff_cap_q;
    if (cfg_i.valid) begin
      if (cap_ext == '0) begin
        eff_cap_d = CmpW'(1);
      end else if (cap_ext > CmpW'(SLOTS)) begin
        eff_cap_d = CmpW'(SLOTS);
      end else begin
        eff_cap_d = cap_ext;
      end
    end
  end

  // Handshake between the input register and the response register.
  assign advance     = req_valid_q && (!rsp_valid_q || rsp_o.ready);
  assign req_i.ready = !req_valid_q || advance;
  assign req_take    = req_i.valid && req_i.ready;
  assign req_valid_d = req_take ? 1'b1 : (advance ? 1'b0 : req_valid_q);
  assign rsp_valid_d = advance ? 1'b1 : (rsp_o.ready ? 1'b0 : rsp_valid_q);

  // Request decode.
  assign is_ins     = (req_op_q == OP_INSERT);
  assign alloc_slot = CntW'(req_slot_q) < count_q;
  assign full       = CmpW'(count_q) >= eff_cap_q;
  assign ins_slot   = full ? tail_q : count_q[SlotW-1:0];
  assign tgt        = is_ins ? ins_slot : req_slot_q;
  assign do_op      = advance && (is_ins || alloc_slot);
  assign evicting   = is_ins && full;
  assign count_m2   = count_q - CntW'(2);

  // Rank of the named slot, and the slot that becomes the tail when the tail leaves.
  always_comb begin
    slot_rank = '0;
    prev_tail = '0;
    for (int j = 0; j < SLOTS; j++) begin
      if (SlotW'(j) == req_slot_q) begin
        slot_rank = slot_rank | rank_q[j];
      end
      if (alloc[j] && (rank_q[j] == count_m2[SlotW-1:0])) begin
        prev_tail = prev_tail | SlotW'(j);
      end
    end
  end

  for (genvar j = 0; j < SLOTS; j++) begin : g_cell
    assign alloc[j] = CntW'(j) < count_q;

    always_ff @(posedge clk_i) begin
      if (do_op) begin
        if (SlotW'(j) == tgt) begin
          rank_q[j] <= '0;
        end else if (alloc[j] && (is_ins || (rank_q[j] < slot_rank))) begin
          rank_q[j] <= rank_q[j] + SlotW'(1);
        end
      end
    end
  end

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (do_op) begin
      head_d = tgt;
      if (is_ins) begin
        if (full) begin
          if (count_q != CntW'(1)) begin
            tail_d = prev_tail;
          end
        end else begin
          count_d = count_q + CntW'(1);
          if (count_q == '0) begin
            tail_d = ins_slot;
          end
        end
      end else if ((req_slot_q == tail_q) && (req_slot_q != head_q)) begin
        tail_d = prev_tail;
      end
    end
  end

  // Hash and value store; the read port follows the tail, with a bypass for a same-cycle write.
  assign ram_wdata = {req_hash_q, req_value_q};
  assign byp_hit_d = do_op && is_ins && (ins_slot == tail_d);
  assign ev_data   = byp_hit_q ? byp_data_q : ram_rdata;

  lrl_ram #(
    .WIDTH (MemW),
    .DEPTH (SLOTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (do_op && is_ins),
    .waddr_i (ins_slot),
    .wdata_i (ram_wdata),
    .raddr_i (tail_d),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eff_cap_q   <= CmpW'(CapResetEff);
      req_valid_q <= 1'b0;
      rsp_valid_q <= 1'b0;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      byp_hit_q   <= 1'b0;
    end else begin
      eff_cap_q   <= eff_cap_d;
      req_valid_q <= req_valid_d;
      rsp_valid_q <= rsp_valid_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      byp_hit_q   <= byp_hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byp_data_q <= ram_wdata;
    if (req_take) begin
      req_op_q    <= req_i.op;
      req_slot_q  <= req_i.slot;
      req_hash_q  <= req_i.key_hash;
      req_value_q <= req_i.value_handle[StoreW-1:0];
    end
    if (advance) begin
      rsp_status_q  <= (!is_ins && !alloc_slot) ? STATUS_UNALLOCATED : STATUS_OK;
      rsp_slot_q    <= head_d;
      rsp_evicted_q <= evicting;
      rsp_hash_q    <= evicting ? ev_data[MemW-1:StoreW] : '0;
      rsp_value_q   <= evicting ? ev_data[StoreW-1:0] : '0;
    end
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.status        = rsp_status_q;
  assign rsp_o.used_slot     = rsp_slot_q;
  assign rsp_o.evicted       = rsp_evicted_q;
  assign rsp_o.evicted_hash  = rsp_hash_q;
  assign rsp_o.evicted_value = HANDLE_W'(rsp_value_q);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(SLOTS))
    else $error("used count exceeds the slot count");

  a_single_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == CntW'(1)) |-> (head_q == tail_q))
    else $error("head and tail differ with one entry");

  a_evict_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && evicting) |=> $stable(count_q))
    else $error("eviction changed the used count");

  a_rsp_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (rsp_slot_q == head_q))
    else $error("response slot does not match the head");

  a_head_rank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) |-> (rank_q[head_q] == '0))
    else $error("head slot does not hold rank zero");

endmodule
